// ===== hdl/gsr_pkg.sv =====
// Shared types and constants for the grid spring relaxation block.
`default_nettype none

package gsr_pkg;

    localparam int IO_COORD_W = 24;
    localparam int IDX_W      = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_BUILD = 2'd1,
        CMD_RELAX = 2'd2,
        CMD_READ  = 2'd3
    } cmd_code_t;

    localparam logic [CFG_IDX_W-1:0] CFG_COLS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STIFF  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PASSES = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FIXED  = 3'd4;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_PT_WRITE,
        OP_PT_READ,
        OP_OUT_LOAD,
        OP_RD_A,
        OP_RD_B,
        OP_SQ_X,
        OP_SQ_Y,
        OP_SUM,
        OP_SQRT_STEP,
        OP_REST_WR,
        OP_MUL,
        OP_DIV_STEP,
        OP_SCALE,
        OP_WR_A,
        OP_WR_B
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   axis;
        logic   move_a;
        logic   move_b;
        logic   in_range;
    } dp_cmd_t;

    typedef struct packed {
        logic dist_zero;
        logic out_busy;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== hdl/gsr_ctrl.sv =====
// Controller: configuration registers, command decode and the spring walk sequencer.
`default_nettype none

module gsr_ctrl #(
    parameter int MAX_COLS   = 32,
    parameter int MAX_ROWS   = 32,
    parameter int COORD_BITS = 24
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [1:0]                       cmd,
    input  wire logic [gsr_pkg::IDX_W-1:0]        point_index,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [gsr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [gsr_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                             out_ready,
    input  wire gsr_pkg::dp_stat_t                stat,
    output gsr_pkg::dp_cmd_t                      dp_cmd,
    output logic [15:0]                           stiffness,
    output logic [$clog2(MAX_COLS*MAX_ROWS)-1:0]  addr_a,
    output logic [$clog2(MAX_COLS*MAX_ROWS)-1:0]  addr_b,
    output logic [$clog2(2*MAX_COLS*MAX_ROWS)-1:0] spring_idx
);
    import gsr_pkg::*;

    localparam int CW    = $clog2(MAX_COLS + 1);
    localparam int RW    = $clog2(MAX_ROWS + 1);
    localparam int AW    = $clog2(MAX_COLS * MAX_ROWS);
    localparam int KW    = $clog2(2 * MAX_COLS * MAX_ROWS);
    localparam int RB    = COORD_BITS + 1;
    localparam int PB    = 2 * RB;
    localparam int CNT_W = $clog2(PB + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_READ, S_INIT, S_SEL, S_ADV, S_RD_A, S_RD_B, S_SQ_X, S_SQ_Y,
        S_SUM, S_SQRT, S_CHK, S_MUL_X, S_DIV_X, S_SC_X, S_MUL_Y, S_DIV_Y,
        S_SC_Y, S_WR_A, S_WR_B, S_NEXT
    } state_t;

    state_t           state_reg;
    logic [5:0]       cols_cfg_reg;
    logic [5:0]       rows_cfg_reg;
    logic [15:0]      stiff_reg;
    logic [7:0]       pass_cfg_reg;
    logic             fixed_reg;
    logic             springs_valid_reg;
    logic             build_reg;
    logic             rd_range_reg;
    logic [CW-1:0]    bcols_reg;
    logic [RW-1:0]    brows_reg;
    logic [CW-1:0]    x_reg;
    logic [RW-1:0]    y_reg;
    logic [AW-1:0]    p_reg;
    logic [KW-1:0]    k_reg;
    logic             j_reg;
    logic [7:0]       passes_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic [CW-1:0]       cols_use;
    logic [RW-1:0]       rows_use;
    logic [CW+RW-1:0]    count;
    logic                in_range;
    logic                in_fire;
    logic                spring_exists;
    logic [CW-1:0]       bx;
    logic [RW-1:0]       by;
    logic                edge_a;
    logic                edge_b;

    always_comb
    begin
        if (cols_cfg_reg < 6'd2)
            cols_use = CW'(2);
        else if (32'(cols_cfg_reg) > 32'(MAX_COLS))
            cols_use = CW'(MAX_COLS);
        else
            cols_use = CW'(cols_cfg_reg);
        if (rows_cfg_reg < 6'd2)
            rows_use = RW'(2);
        else if (32'(rows_cfg_reg) > 32'(MAX_ROWS))
            rows_use = RW'(MAX_ROWS);
        else
            rows_use = RW'(rows_cfg_reg);
    end

    assign count     = {{RW{1'b0}}, cols_use} * {{CW{1'b0}}, rows_use};
    assign in_range  = 32'(point_index) < 32'(count);
    assign in_ready  = (state_reg == S_IDLE) && (!stat.out_busy || out_ready);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign stiffness = stiff_reg;

    assign spring_exists = j_reg ? ((RW'(y_reg) + RW'(1)) < brows_reg)
                                 : ((x_reg + CW'(1)) < bcols_reg);
    assign bx = j_reg ? x_reg : x_reg + CW'(1);
    assign by = j_reg ? y_reg + RW'(1) : y_reg;
    assign edge_a = (y_reg == '0) || (y_reg == brows_reg - RW'(1)) ||
                    (x_reg == '0) || (x_reg == bcols_reg - CW'(1));
    assign edge_b = (by == '0) || (by == brows_reg - RW'(1)) ||
                    (bx == '0) || (bx == bcols_reg - CW'(1));

    assign addr_a     = p_reg;
    assign addr_b     = j_reg ? p_reg + AW'(bcols_reg) : p_reg + AW'(1);
    assign spring_idx = k_reg;

    always_comb
    begin
        dp_cmd.op       = OP_NONE;
        dp_cmd.axis     = 1'b0;
        dp_cmd.move_a   = !fixed_reg || !edge_a;
        dp_cmd.move_b   = !fixed_reg || !edge_b;
        dp_cmd.in_range = (state_reg == S_READ) ? rd_range_reg : in_range;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire && cmd == CMD_WRITE)
                    dp_cmd.op = OP_PT_WRITE;
                else if (in_fire && cmd == CMD_READ)
                    dp_cmd.op = OP_PT_READ;
            end
            S_READ:  dp_cmd.op = OP_OUT_LOAD;
            S_RD_A:  dp_cmd.op = OP_RD_A;
            S_RD_B:  dp_cmd.op = OP_RD_B;
            S_SQ_X:  dp_cmd.op = OP_SQ_X;
            S_SQ_Y:  dp_cmd.op = OP_SQ_Y;
            S_SUM:   dp_cmd.op = OP_SUM;
            S_SQRT:  dp_cmd.op = OP_SQRT_STEP;
            S_CHK:   dp_cmd.op = build_reg ? OP_REST_WR : OP_NONE;
            S_MUL_X: dp_cmd.op = OP_MUL;
            S_DIV_X: dp_cmd.op = OP_DIV_STEP;
            S_SC_X:  dp_cmd.op = OP_SCALE;
            S_MUL_Y:
            begin
                dp_cmd.op   = OP_MUL;
                dp_cmd.axis = 1'b1;
            end
            S_DIV_Y: dp_cmd.op = OP_DIV_STEP;
            S_SC_Y:
            begin
                dp_cmd.op   = OP_SCALE;
                dp_cmd.axis = 1'b1;
            end
            S_WR_A:  dp_cmd.op = OP_WR_A;
            S_WR_B:  dp_cmd.op = OP_WR_B;
            S_INIT, S_SEL, S_ADV, S_NEXT: dp_cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            cols_cfg_reg      <= 6'd2;
            rows_cfg_reg      <= 6'd2;
            stiff_reg         <= 16'd16384;
            pass_cfg_reg      <= 8'd10;
            fixed_reg         <= 1'b0;
            springs_valid_reg <= 1'b0;
            build_reg         <= 1'b0;
            rd_range_reg      <= 1'b0;
            bcols_reg         <= CW'(2);
            brows_reg         <= RW'(2);
            x_reg             <= '0;
            y_reg             <= '0;
            p_reg             <= '0;
            k_reg             <= '0;
            j_reg             <= 1'b0;
            passes_reg        <= '0;
            cnt_reg           <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_COLS:   cols_cfg_reg <= cfg_data[5:0];
                    CFG_ROWS:   rows_cfg_reg <= cfg_data[5:0];
                    CFG_STIFF:  stiff_reg    <= cfg_data;
                    CFG_PASSES: pass_cfg_reg <= cfg_data[7:0];
                    CFG_FIXED:  fixed_reg    <= cfg_data[0];
                    default:    ;
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        unique case (cmd)
                            CMD_WRITE: ;
                            CMD_READ:
                            begin
                                rd_range_reg <= in_range;
                                state_reg    <= S_READ;
                            end
                            CMD_BUILD:
                            begin
                                bcols_reg         <= cols_use;
                                brows_reg         <= rows_use;
                                springs_valid_reg <= 1'b1;
                                build_reg         <= 1'b1;
                                state_reg         <= S_INIT;
                            end
                            CMD_RELAX:
                            begin
                                if (springs_valid_reg && pass_cfg_reg != 8'd0)
                                begin
                                    build_reg  <= 1'b0;
                                    passes_reg <= pass_cfg_reg;
                                    state_reg  <= S_INIT;
                                end
                            end
                        endcase
                    end
                end
                S_READ: state_reg <= S_IDLE;
                S_INIT:
                begin
                    x_reg     <= '0;
                    y_reg     <= '0;
                    p_reg     <= '0;
                    k_reg     <= '0;
                    j_reg     <= 1'b0;
                    state_reg <= S_SEL;
                end
                S_SEL: state_reg <= spring_exists ? S_RD_A : S_ADV;
                S_ADV:
                begin
                    if (!j_reg)
                    begin
                        j_reg     <= 1'b1;
                        state_reg <= S_SEL;
                    end
                    else
                    begin
                        j_reg <= 1'b0;
                        if (x_reg == bcols_reg - CW'(1))
                        begin
                            x_reg <= '0;
                            if (y_reg == brows_reg - RW'(1))
                            begin
                                // End of one pass over all springs.
                                if (build_reg || passes_reg == 8'd1)
                                    state_reg <= S_IDLE;
                                else
                                begin
                                    passes_reg <= passes_reg - 8'd1;
                                    state_reg  <= S_INIT;
                                end
                            end
                            else
                            begin
                                y_reg     <= y_reg + RW'(1);
                                p_reg     <= p_reg + AW'(1);
                                state_reg <= S_SEL;
                            end
                        end
                        else
                        begin
                            x_reg     <= x_reg + CW'(1);
                            p_reg     <= p_reg + AW'(1);
                            state_reg <= S_SEL;
                        end
                    end
                end
                S_RD_A: state_reg <= S_RD_B;
                S_RD_B: state_reg <= S_SQ_X;
                S_SQ_X: state_reg <= S_SQ_Y;
                S_SQ_Y: state_reg <= S_SUM;
                S_SUM:
                begin
                    cnt_reg   <= CNT_W'(RB);
                    state_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    cnt_reg <= cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1))
                        state_reg <= S_CHK;
                end
                S_CHK:
                begin
                    if (build_reg || stat.dist_zero)
                        state_reg <= S_NEXT;
                    else
                        state_reg <= S_MUL_X;
                end
                S_MUL_X:
                begin
                    cnt_reg   <= CNT_W'(PB);
                    state_reg <= S_DIV_X;
                end
                S_DIV_X:
                begin
                    cnt_reg <= cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1))
                        state_reg <= S_SC_X;
                end
                S_SC_X: state_reg <= S_MUL_Y;
                S_MUL_Y:
                begin
                    cnt_reg   <= CNT_W'(PB);
                    state_reg <= S_DIV_Y;
                end
                S_DIV_Y:
                begin
                    cnt_reg <= cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1))
                        state_reg <= S_SC_Y;
                end
                S_SC_Y: state_reg <= S_WR_A;
                S_WR_A: state_reg <= S_WR_B;
                S_WR_B: state_reg <= S_NEXT;
                S_NEXT:
                begin
                    k_reg     <= k_reg + KW'(1);
                    state_reg <= S_ADV;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/gsr_datapath.sv =====
// Datapath: point and rest-length memories, square root, divider and correction arithmetic.
`default_nettype none

module gsr_datapath #(
    parameter int MAX_COLS   = 32,
    parameter int MAX_ROWS   = 32,
    parameter int COORD_BITS = 24
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire gsr_pkg::dp_cmd_t                        dp_cmd,
    output gsr_pkg::dp_stat_t                            stat,
    input  wire logic [15:0]                             stiffness,
    input  wire logic [gsr_pkg::IDX_W-1:0]               point_index,
    input  wire logic signed [gsr_pkg::IO_COORD_W-1:0]   coord_x,
    input  wire logic signed [gsr_pkg::IO_COORD_W-1:0]   coord_y,
    input  wire logic [$clog2(MAX_COLS*MAX_ROWS)-1:0]    addr_a,
    input  wire logic [$clog2(MAX_COLS*MAX_ROWS)-1:0]    addr_b,
    input  wire logic [$clog2(2*MAX_COLS*MAX_ROWS)-1:0]  spring_idx,
    input  wire logic                                    out_ready,
    output logic                                         out_valid,
    output logic signed [gsr_pkg::IO_COORD_W-1:0]        read_x,
    output logic signed [gsr_pkg::IO_COORD_W-1:0]        read_y
);
    import gsr_pkg::*;

    localparam int C    = COORD_BITS;
    localparam int RB   = C + 1;
    localparam int PB   = 2 * RB;
    localparam int NPTS = MAX_COLS * MAX_ROWS;
    localparam int AW   = $clog2(NPTS);
    localparam int NSPR = 2 * NPTS;
    localparam int KW   = $clog2(NSPR);
    localparam int IW   = ((C > IO_COORD_W) ? C : IO_COORD_W) + 1;

    localparam logic signed [IW-1:0]  CMAX_I = {{(IW-C+1){1'b0}}, {(C-1){1'b1}}};
    localparam logic signed [IW-1:0]  OMAX_I = {{(IW-IO_COORD_W+1){1'b0}},
                                                {(IO_COORD_W-1){1'b1}}};
    localparam logic signed [C+2:0]   CMAX_S = {4'b0000, {(C-1){1'b1}}};
    localparam logic signed [IW-1:0]  CMIN_I = ~CMAX_I;
    localparam logic signed [IW-1:0]  OMIN_I = ~OMAX_I;
    localparam logic signed [C+2:0]   CMIN_S = ~CMAX_S;

    function automatic logic signed [C-1:0] sat_in(input logic signed [IO_COORD_W-1:0] v);
        logic signed [IW-1:0] e;
        e = {{(IW-IO_COORD_W){v[IO_COORD_W-1]}}, v};
        if (e > CMAX_I)
            return CMAX_I[C-1:0];
        else if (e < CMIN_I)
            return CMIN_I[C-1:0];
        else
            return e[C-1:0];
    endfunction

    function automatic logic signed [IO_COORD_W-1:0] sat_out(input logic signed [C-1:0] v);
        logic signed [IW-1:0] e;
        e = {{(IW-C){v[C-1]}}, v};
        if (e > OMAX_I)
            return OMAX_I[IO_COORD_W-1:0];
        else if (e < OMIN_I)
            return OMIN_I[IO_COORD_W-1:0];
        else
            return e[IO_COORD_W-1:0];
    endfunction

    function automatic logic signed [C-1:0] sat_sum(input logic signed [C+2:0] v);
        if (v > CMAX_S)
            return CMAX_S[C-1:0];
        else if (v < CMIN_S)
            return CMIN_S[C-1:0];
        else
            return v[C-1:0];
    endfunction

    logic signed [C-1:0] xs_mem [NPTS];
    logic signed [C-1:0] ys_mem [NPTS];
    logic [C-1:0]        rest_mem [NSPR];

    logic signed [C-1:0] rdx_reg, rdy_reg, xa_reg, ya_reg;
    logic [C-1:0]        rest_reg;
    logic [PB-1:0]       sq_reg, acc_reg, rad_reg, prod_reg;
    logic [RB+1:0]       srem_reg;
    logic [RB-1:0]       root_reg;
    logic [RB:0]         drem_reg;
    logic [RB-1:0]       q_reg;
    logic signed [RB:0]  cx_reg, cy_reg;
    logic                out_valid_reg;
    logic signed [IO_COORD_W-1:0] out_x_reg, out_y_reg;

    logic [31:0]         idx_ext;
    logic [AW-1:0]       in_addr;
    logic signed [C:0]   dx, dy;
    logic [RB-1:0]       ux, uy, ud;
    logic signed [RB:0]  diff;
    logic [RB-1:0]       udiff;
    logic                d_neg;
    logic [RB-1:0]       ma, mb;
    logic [PB-1:0]       mprod;
    logic [RB+15:0]      sprod;
    logic [RB-1:0]       cmag;
    logic signed [RB:0]  cval;
    logic [RB+3:0]       sq_new, sq_trial;
    logic [RB+1:0]       dv_new;
    logic [C-1:0]        rest_w;
    logic                mem_we, mem_re;
    logic [AW-1:0]       waddr, raddr;
    logic signed [C-1:0] wx, wy;

    assign idx_ext = 32'(point_index);
    assign in_addr = idx_ext[AW-1:0];

    assign dx    = {rdx_reg[C-1], rdx_reg} - {xa_reg[C-1], xa_reg};
    assign dy    = {rdy_reg[C-1], rdy_reg} - {ya_reg[C-1], ya_reg};
    assign ux    = dx[C] ? RB'(-dx) : RB'(dx);
    assign uy    = dy[C] ? RB'(-dy) : RB'(dy);
    assign ud    = dp_cmd.axis ? uy : ux;
    assign d_neg = dp_cmd.axis ? dy[C] : dx[C];
    assign diff  = {1'b0, root_reg} - {2'b00, rest_reg};
    assign udiff = diff[RB] ? RB'(-diff) : RB'(diff);

    // One shared multiplier for both squares and the stretch product.
    always_comb
    begin
        unique case (dp_cmd.op)
            OP_SQ_X: begin ma = ux; mb = ux;    end
            OP_SQ_Y: begin ma = uy; mb = uy;    end
            default: begin ma = ud; mb = udiff; end
        endcase
    end
    assign mprod = ma * mb;

    assign sprod = q_reg * stiffness;
    assign cmag  = sprod[RB+15:16];
    assign cval  = (d_neg != diff[RB]) ? -$signed({1'b0, cmag}) : $signed({1'b0, cmag});

    assign sq_new   = {srem_reg, rad_reg[PB-1:PB-2]};
    assign sq_trial = (RB+4)'({root_reg, 2'b01});
    assign dv_new   = {drem_reg, prod_reg[PB-1]};

    assign rest_w = root_reg[RB-1] ? {C{1'b1}} : root_reg[C-1:0];

    always_comb
    begin
        mem_we = 1'b0;
        mem_re = 1'b0;
        waddr  = addr_a;
        raddr  = addr_a;
        wx     = sat_sum((C+3)'(xa_reg) + (C+3)'(cx_reg));
        wy     = sat_sum((C+3)'(ya_reg) + (C+3)'(cy_reg));
        unique case (dp_cmd.op)
            OP_PT_WRITE:
            begin
                mem_we = dp_cmd.in_range;
                waddr  = in_addr;
                wx     = sat_in(coord_x);
                wy     = sat_in(coord_y);
            end
            OP_PT_READ:
            begin
                mem_re = 1'b1;
                raddr  = in_addr;
            end
            OP_RD_A: mem_re = 1'b1;
            OP_RD_B:
            begin
                mem_re = 1'b1;
                raddr  = addr_b;
            end
            OP_WR_A: mem_we = dp_cmd.move_a;
            OP_WR_B:
            begin
                mem_we = dp_cmd.move_b;
                waddr  = addr_b;
                wx     = sat_sum((C+3)'(rdx_reg) - (C+3)'(cx_reg));
                wy     = sat_sum((C+3)'(rdy_reg) - (C+3)'(cy_reg));
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            xs_mem[waddr] <= wx;
            ys_mem[waddr] <= wy;
        end
        if (mem_re)
        begin
            rdx_reg <= xs_mem[raddr];
            rdy_reg <= ys_mem[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.op == OP_REST_WR)
            rest_mem[spring_idx] <= rest_w;
        if (dp_cmd.op == OP_RD_B)
            rest_reg <= rest_mem[spring_idx];
    end

    always_ff @(posedge clk)
    begin
        unique case (dp_cmd.op)
            OP_RD_B:
            begin
                xa_reg <= rdx_reg;
                ya_reg <= rdy_reg;
            end
            OP_SQ_X: sq_reg <= mprod;
            OP_SQ_Y:
            begin
                acc_reg <= sq_reg;
                sq_reg  <= mprod;
            end
            OP_SUM:
            begin
                rad_reg  <= acc_reg + sq_reg;
                srem_reg <= '0;
                root_reg <= '0;
            end
            OP_SQRT_STEP:
            begin
                rad_reg <= {rad_reg[PB-3:0], 2'b00};
                if (sq_new >= sq_trial)
                begin
                    srem_reg <= (RB+2)'(sq_new - sq_trial);
                    root_reg <= {root_reg[RB-2:0], 1'b1};
                end
                else
                begin
                    srem_reg <= sq_new[RB+1:0];
                    root_reg <= {root_reg[RB-2:0], 1'b0};
                end
            end
            OP_MUL:
            begin
                prod_reg <= mprod;
                drem_reg <= '0;
                q_reg    <= '0;
            end
            OP_DIV_STEP:
            begin
                prod_reg <= {prod_reg[PB-2:0], 1'b0};
                if (dv_new >= (RB+2)'(root_reg))
                begin
                    drem_reg <= (RB+1)'(dv_new - (RB+2)'(root_reg));
                    q_reg    <= {q_reg[RB-2:0], 1'b1};
                end
                else
                begin
                    drem_reg <= dv_new[RB:0];
                    q_reg    <= {q_reg[RB-2:0], 1'b0};
                end
            end
            OP_SCALE:
            begin
                if (dp_cmd.axis)
                    cy_reg <= cval;
                else
                    cx_reg <= cval;
            end
            OP_OUT_LOAD:
            begin
                out_x_reg <= dp_cmd.in_range ? sat_out(rdx_reg) : '0;
                out_y_reg <= dp_cmd.in_range ? sat_out(rdy_reg) : '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (dp_cmd.op == OP_OUT_LOAD)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign out_valid      = out_valid_reg;
    assign read_x         = out_x_reg;
    assign read_y         = out_y_reg;
    assign stat.out_busy  = out_valid_reg;
    assign stat.dist_zero = (root_reg == '0);

endmodule

`default_nettype wire

// ===== hdl/grid_spring_relaxation_top.sv =====
// Top level of the grid spring relaxation block: controller, datapath and checks.
//
//  Channel   Signals                                        Direction
//  input     in_valid/in_ready, cmd, point_index, coord_*   in
//  result    out_valid/out_ready, read_x, read_y            out
//  config    cfg_valid/cfg_ready, cfg_index, cfg_data       in
//
// Point writes can be transferred back to back while no result is held or it is being taken.
// A point read first does a registered memory read and then loads the result
// register; the result then waits there until transferred.
// Build and relax walk the springs through one shared multiplier, a one-bit-per-cycle
// square root and a one-bit-per-cycle divider.
// Reset clears the control state and loads the configuration defaults; the point and
// rest-length memories are not cleared. A held result stalls only a following command.
`default_nettype none

module grid_spring_relaxation_top #(
    parameter int MAX_COLS   = 32,
    parameter int MAX_ROWS   = 32,
    parameter int COORD_BITS = 24
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic [1:0]                             cmd,
    input  wire logic [gsr_pkg::IDX_W-1:0]              point_index,
    input  wire logic signed [gsr_pkg::IO_COORD_W-1:0]  coord_x,
    input  wire logic signed [gsr_pkg::IO_COORD_W-1:0]  coord_y,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic signed [gsr_pkg::IO_COORD_W-1:0]       read_x,
    output logic signed [gsr_pkg::IO_COORD_W-1:0]       read_y,
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [gsr_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [gsr_pkg::CFG_DATA_W-1:0]         cfg_data
);
    import gsr_pkg::*;

    localparam int AW = $clog2(MAX_COLS * MAX_ROWS);
    localparam int KW = $clog2(2 * MAX_COLS * MAX_ROWS);

    dp_cmd_t       dp_cmd;
    dp_stat_t      stat;
    logic [15:0]   stiffness;
    logic [AW-1:0] addr_a;
    logic [AW-1:0] addr_b;
    logic [KW-1:0] spring_idx;

    // The controller owns configuration and sequencing; it sends commands, addresses and stiffness.
    gsr_ctrl #(
        .MAX_COLS   (MAX_COLS),
        .MAX_ROWS   (MAX_ROWS),
        .COORD_BITS (COORD_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .point_index (point_index),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_ready   (out_ready),
        .stat        (stat),
        .dp_cmd      (dp_cmd),
        .stiffness   (stiffness),
        .addr_a      (addr_a),
        .addr_b      (addr_b),
        .spring_idx  (spring_idx)
    );

    // The datapath holds the memories, the arithmetic units and the result register.
    gsr_datapath #(
        .MAX_COLS   (MAX_COLS),
        .MAX_ROWS   (MAX_ROWS),
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .dp_cmd      (dp_cmd),
        .stat        (stat),
        .stiffness   (stiffness),
        .point_index (point_index),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .addr_a      (addr_a),
        .addr_b      (addr_b),
        .spring_idx  (spring_idx),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .read_x      (read_x),
        .read_y      (read_y)
    );

    // A new command is taken only when the result register can be freed.
    a_ready_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (!out_valid || out_ready))
        else $error("input taken while a result is held");

    // Point writes to memory happen only on an accepted transfer.
    a_write_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (dp_cmd.op == OP_PT_WRITE) |-> (in_valid && in_ready))
        else $error("point write without an input transfer");

    // Loading the result register always raises out_valid.
    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (dp_cmd.op == OP_OUT_LOAD) |=> out_valid)
        else $error("result load did not raise out_valid");

    // After a read is accepted the block is busy for its load cycle.
    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && cmd == CMD_READ) |=> !in_ready)
        else $error("input ready during a read load");

endmodule

`default_nettype wire
